// ===== sv/smc_pkg.sv =====
// ----------------------------------------------------------------------------
// smc_pkg
// Shared types, constants and helpers of the small matrix calculator.
// ----------------------------------------------------------------------------
package smc_pkg;

    localparam int SIDE     = 8;
    localparam int MAX_DIM  = 8;
    localparam int IDX_W    = 3;
    localparam int ACC_W    = 36;
    localparam int WAIT_LEN = SIDE + 1;

    localparam logic [2:0] CFG_OPERATION = 3'd0;
    localparam logic [2:0] CFG_ROWS_A    = 3'd1;
    localparam logic [2:0] CFG_COLS_A    = 3'd2;
    localparam logic [2:0] CFG_ROWS_B    = 3'd3;
    localparam logic [2:0] CFG_COLS_B    = 3'd4;
    localparam logic [2:0] CFG_SCALAR    = 3'd5;

    typedef enum logic [1:0] {
        OP_WR_A  = 2'd0,
        OP_WR_B  = 2'd1,
        OP_START = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        M_ADD = 2'd0,
        M_SUB = 2'd1,
        M_SCL = 2'd2,
        M_MAC = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SHAPE = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_FEED,
        S_WAIT,
        S_LOAD,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic               valid;
        t_mode              mode;
        logic [IDX_W-1:0]   k;
        logic signed [15:0] x;
    } t_tok;

    typedef struct packed {
        logic [IDX_W-1:0]   row;
        logic               order;
        logic               load;
        logic               shift;
        logic signed [15:0] scalar;
    } t_ctl;

    typedef struct packed {
        logic             we_a;
        logic             we_b;
        logic [IDX_W-1:0] row;
        logic [15:0]      value;
    } t_wr;

    function automatic logic dim_ok(input logic [3:0] d);
        dim_ok = (d != 4'd0) && ({28'd0, d} <= 32'(MAX_DIM)) && ({28'd0, d} <= 32'(SIDE));
    endfunction

    function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(signed'(32'h7FFF_FFFF))) begin
            sat32 = 32'h7FFF_FFFF;
        end else if (v < ACC_W'(signed'(32'h8000_0000))) begin
            sat32 = 32'h8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

endpackage

// ===== sv/smc_cell.sv =====
// ----------------------------------------------------------------------------
// smc_cell
// One result column: column storage of A and B, a multiply stage, an
// accumulator and a result register that shifts towards cell zero.
// ----------------------------------------------------------------------------
module smc_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  smc_pkg::t_ctl          i_ctl,
    input  smc_pkg::t_wr           i_wr,
    input  smc_pkg::t_tok          i_tok,
    output smc_pkg::t_tok          o_tok,
    output logic signed [15:0]     o_left,
    input  logic [31:0]            i_res,
    output logic [31:0]            o_res
);

    logic [15:0]                          r_a [smc_pkg::SIDE];
    logic [15:0]                          r_b [smc_pkg::SIDE];
    smc_pkg::t_tok                        r_tok;
    logic                                 r_pv;
    logic                                 r_pfirst;
    logic                                 r_pmac;
    logic signed [smc_pkg::ACC_W-1:0]     r_p;
    logic                                 r_amac;
    logic signed [smc_pkg::ACC_W-1:0]     r_acc;
    logic [31:0]                          r_res;

    logic [smc_pkg::IDX_W-1:0]            addr_a;
    logic [smc_pkg::IDX_W-1:0]            addr_b;
    logic signed [15:0]                   rd_a;
    logic signed [15:0]                   rd_b;
    logic signed [15:0]                   mul_x;
    logic signed [15:0]                   mul_y;
    logic signed [31:0]                   prod;
    logic signed [smc_pkg::ACC_W-1:0]     n_p;
    logic signed [smc_pkg::ACC_W-1:0]     rnd;
    logic                                 mac;

    assign addr_a = i_ctl.order ? r_tok.k : i_ctl.row;
    assign addr_b = i_ctl.order ? i_ctl.row : r_tok.k;
    assign rd_a   = signed'(r_a[addr_a]);
    assign rd_b   = signed'(r_b[addr_b]);
    assign o_left = i_ctl.order ? rd_b : rd_a;
    assign mac    = (r_tok.mode == smc_pkg::M_MAC);

    always_comb begin
        mul_x = mac ? r_tok.x : rd_a;
        mul_y = mac ? (i_ctl.order ? rd_a : rd_b) : i_ctl.scalar;
        prod  = mul_x * mul_y;
        case (r_tok.mode)
            smc_pkg::M_ADD: n_p = smc_pkg::ACC_W'(rd_a) + smc_pkg::ACC_W'(rd_b);
            smc_pkg::M_SUB: n_p = smc_pkg::ACC_W'(rd_a) - smc_pkg::ACC_W'(rd_b);
            default:        n_p = smc_pkg::ACC_W'(prod);
        endcase
        rnd = (r_acc + smc_pkg::ACC_W'(128)) >>> 8;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we_a) begin
            r_a[i_wr.row] <= i_wr.value;
        end
        if (i_wr.we_b) begin
            r_b[i_wr.row] <= i_wr.value;
        end
        r_p        <= n_p;
        r_pfirst   <= !mac || (r_tok.k == '0);
        r_pmac     <= mac;
        if (r_pv) begin
            r_acc  <= r_pfirst ? r_p : r_acc + r_p;
            r_amac <= r_pmac;
        end
        if (i_ctl.load) begin
            r_res <= r_amac ? smc_pkg::sat32(rnd) : smc_pkg::sat32(r_acc);
        end else if (i_ctl.shift) begin
            r_res <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
            r_pv  <= 1'b0;
        end else begin
            r_tok <= i_tok;
            r_pv  <= r_tok.valid;
        end
    end

    assign o_tok = r_tok;
    assign o_res = r_res;

endmodule

// ===== sv/smc_ctrl.sv =====
// ----------------------------------------------------------------------------
// smc_ctrl
// Sequencer: shape checks, row and inner-index counting, token injection
// into the cell chain and result emission.
// ----------------------------------------------------------------------------
module smc_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [1:0]                    i_operation,
    input  logic [3:0]                    i_rows_a,
    input  logic [3:0]                    i_cols_a,
    input  logic [3:0]                    i_rows_b,
    input  logic [3:0]                    i_cols_b,
    input  logic signed [15:0]            i_scalar,
    input  logic signed [15:0]            i_left [smc_pkg::SIDE],
    input  logic [31:0]                   i_res,
    output smc_pkg::t_ctl                 o_ctl,
    output smc_pkg::t_tok                 o_tok,
    output logic                          o_busy,
    output logic                          o_valid,
    output logic [2:0]                    o_out_row,
    output logic [2:0]                    o_out_col,
    output logic [31:0]                   o_out_value,
    output logic [1:0]                    o_status,
    output logic                          o_order,
    output logic                          o_last
);

    smc_pkg::t_state            r_state, n_state;
    smc_pkg::t_mode             r_mode, n_mode;
    smc_pkg::t_status           r_stat, n_stat;
    logic                       r_order, n_order;
    logic [3:0]                 r_nr, n_nr;
    logic [3:0]                 r_nc, n_nc;
    logic [3:0]                 r_inner, n_inner;
    logic [smc_pkg::IDX_W-1:0]  r_i, n_i;
    logic [smc_pkg::IDX_W-1:0]  r_j, n_j;
    logic [smc_pkg::IDX_W-1:0]  r_k, n_k;
    logic [3:0]                 r_cnt, n_cnt;

    logic                       r_valid, n_valid;
    logic [2:0]                 r_orow, n_orow;
    logic [2:0]                 r_ocol, n_ocol;
    logic [31:0]                r_oval, n_oval;
    logic [1:0]                 r_ostat, n_ostat;
    logic                       r_oord, n_oord;
    logic                       r_olast, n_olast;

    logic                       last_i;
    logic                       last_j;

    assign last_i = ({1'b0, r_i} == r_nr - 4'd1);
    assign last_j = ({1'b0, r_j} == r_nc - 4'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smc_pkg::S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_stat  <= n_stat;
        r_order <= n_order;
        r_nr    <= n_nr;
        r_nc    <= n_nc;
        r_inner <= n_inner;
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_cnt   <= n_cnt;
        r_orow  <= n_orow;
        r_ocol  <= n_ocol;
        r_oval  <= n_oval;
        r_ostat <= n_ostat;
        r_oord  <= n_oord;
        r_olast <= n_olast;
    end

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_stat  = r_stat;
        n_order = r_order;
        n_nr    = r_nr;
        n_nc    = r_nc;
        n_inner = r_inner;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_cnt   = r_cnt;
        n_valid = 1'b0;
        n_orow  = r_orow;
        n_ocol  = r_ocol;
        n_oval  = r_oval;
        n_ostat = r_ostat;
        n_oord  = r_oord;
        n_olast = r_olast;

        o_tok       = '0;
        o_tok.mode  = r_mode;
        o_ctl.row   = r_i;
        o_ctl.order = r_order;
        o_ctl.load  = 1'b0;
        o_ctl.shift = 1'b0;
        o_ctl.scalar = i_scalar;

        case (r_state)
            smc_pkg::S_IDLE: begin
                if (i_go) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                    n_order = 1'b0;
                    n_stat  = smc_pkg::ST_OK;
                    n_mode  = smc_pkg::t_mode'(i_operation);
                    n_state = smc_pkg::S_FEED;
                    if (i_operation != smc_pkg::M_MAC) begin
                        n_nr    = i_rows_a;
                        n_nc    = i_rows_a;
                        n_inner = 4'd1;
                        if (!smc_pkg::dim_ok(i_rows_a)) begin
                            n_stat  = smc_pkg::ST_RANGE;
                            n_state = smc_pkg::S_ERR;
                        end
                    end else if (!smc_pkg::dim_ok(i_rows_a) || !smc_pkg::dim_ok(i_cols_a) ||
                                 !smc_pkg::dim_ok(i_rows_b) || !smc_pkg::dim_ok(i_cols_b)) begin
                        n_stat  = smc_pkg::ST_RANGE;
                        n_state = smc_pkg::S_ERR;
                    end else if (i_cols_a == i_rows_b) begin
                        n_nr    = i_rows_a;
                        n_nc    = i_cols_b;
                        n_inner = i_cols_a;
                    end else if (i_cols_b == i_rows_a) begin
                        n_order = 1'b1;
                        n_nr    = i_rows_b;
                        n_nc    = i_cols_a;
                        n_inner = i_rows_a;
                    end else begin
                        n_stat  = smc_pkg::ST_SHAPE;
                        n_state = smc_pkg::S_ERR;
                    end
                end
            end
            smc_pkg::S_ERR: begin
                n_valid = 1'b1;
                n_orow  = '0;
                n_ocol  = '0;
                n_oval  = '0;
                n_ostat = r_stat;
                n_oord  = 1'b0;
                n_olast = 1'b1;
                n_state = smc_pkg::S_IDLE;
            end
            smc_pkg::S_FEED: begin
                o_tok.valid = 1'b1;
                o_tok.k     = (r_mode == smc_pkg::M_MAC) ? r_k : r_i;
                o_tok.x     = i_left[r_k];
                n_k         = r_k + 1'b1;
                if ({1'b0, r_k} == r_inner - 4'd1) begin
                    n_cnt   = '0;
                    n_state = smc_pkg::S_WAIT;
                end
            end
            smc_pkg::S_WAIT: begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'(smc_pkg::WAIT_LEN - 1)) begin
                    n_state = smc_pkg::S_LOAD;
                end
            end
            smc_pkg::S_LOAD: begin
                o_ctl.load = 1'b1;
                n_j        = '0;
                n_state    = smc_pkg::S_DRAIN;
            end
            smc_pkg::S_DRAIN: begin
                o_ctl.shift = 1'b1;
                n_valid = 1'b1;
                n_orow  = r_i;
                n_ocol  = r_j;
                n_oval  = i_res;
                n_ostat = smc_pkg::ST_OK;
                n_oord  = r_order;
                n_olast = last_i && last_j;
                n_j     = r_j + 1'b1;
                if (last_j) begin
                    if (last_i) begin
                        n_state = smc_pkg::S_IDLE;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_k     = '0;
                        n_state = smc_pkg::S_FEED;
                    end
                end
            end
            default: begin
                n_state = smc_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state != smc_pkg::S_IDLE);
    assign o_valid     = r_valid;
    assign o_out_row   = r_orow;
    assign o_out_col   = r_ocol;
    assign o_out_value = r_oval;
    assign o_status    = r_ostat;
    assign o_order     = r_oord;
    assign o_last      = r_olast;

endmodule

// ===== sv/small_matrix_calculator.sv =====
// ----------------------------------------------------------------------------
// small_matrix_calculator
// Element-wise add, subtract, scale and matrix product over an eight-cell
// chain, one cell per result column.
// ----------------------------------------------------------------------------
// Element writes can follow back to back while the block is not busy.
// Each result row passes through the feed, wait, load and drain states, feeding
// inner tokens, inner being 1 for add, subtract and scale.
// Size or shape errors give a single result through the error state after the start transaction.
// Results are shown one cycle each; the receiver cannot stall.
// Synchronous active-low reset clears state, valid and token flags and sets config registers; stores undefined.
module small_matrix_calculator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_op,
    input  logic [2:0]         i_row,
    input  logic [2:0]         i_col,
    input  logic signed [15:0] i_value,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    output logic [2:0]         o_out_row,
    output logic [2:0]         o_out_col,
    output logic signed [31:0] o_out_value,
    output logic [1:0]         o_status,
    output logic               o_order,
    output logic               o_last
);

    logic [1:0]          r_operation;
    logic [3:0]          r_rows_a;
    logic [3:0]          r_cols_a;
    logic [3:0]          r_rows_b;
    logic [3:0]          r_cols_b;
    logic signed [15:0]  r_scalar;

    logic                accept;
    smc_pkg::t_ctl       ctl;
    smc_pkg::t_tok       tok [smc_pkg::SIDE+1];
    logic signed [15:0]  left [smc_pkg::SIDE];
    logic [31:0]         res [smc_pkg::SIDE+1];
    smc_pkg::t_wr        wr [smc_pkg::SIDE];
    logic [31:0]         out_value;

    assign accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_operation <= 2'd0;
            r_rows_a    <= 4'd1;
            r_cols_a    <= 4'd1;
            r_rows_b    <= 4'd1;
            r_cols_b    <= 4'd1;
            r_scalar    <= 16'sd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                smc_pkg::CFG_OPERATION: r_operation <= i_cfg_data[1:0];
                smc_pkg::CFG_ROWS_A:    r_rows_a    <= i_cfg_data[3:0];
                smc_pkg::CFG_COLS_A:    r_cols_a    <= i_cfg_data[3:0];
                smc_pkg::CFG_ROWS_B:    r_rows_b    <= i_cfg_data[3:0];
                smc_pkg::CFG_COLS_B:    r_cols_b    <= i_cfg_data[3:0];
                smc_pkg::CFG_SCALAR:    r_scalar    <= signed'(i_cfg_data);
                default: ;
            endcase
        end
    end

    smc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (accept && (i_op == smc_pkg::OP_START)),
        .i_operation (r_operation),
        .i_rows_a    (r_rows_a),
        .i_cols_a    (r_cols_a),
        .i_rows_b    (r_rows_b),
        .i_cols_b    (r_cols_b),
        .i_scalar    (r_scalar),
        .i_left      (left),
        .i_res       (res[0]),
        .o_ctl       (ctl),
        .o_tok       (tok[0]),
        .o_busy      (o_busy),
        .o_valid     (o_valid),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_out_value (out_value),
        .o_status    (o_status),
        .o_order     (o_order),
        .o_last      (o_last)
    );

    assign o_out_value      = signed'(out_value);
    assign res[smc_pkg::SIDE] = '0;

    for (genvar g = 0; g < smc_pkg::SIDE; g++) begin : g_cell
        always_comb begin
            wr[g].we_a  = accept && (i_op == smc_pkg::OP_WR_A) &&
                          (i_col == smc_pkg::IDX_W'(g));
            wr[g].we_b  = accept && (i_op == smc_pkg::OP_WR_B) &&
                          (i_col == smc_pkg::IDX_W'(g));
            wr[g].row   = i_row;
            wr[g].value = i_value;
        end

        smc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_wr    (wr[g]),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1]),
            .o_left  (left[g]),
            .i_res   (res[g+1]),
            .o_res   (res[g])
        );
    end

endmodule

// ===== sv/smc_checker.sv =====
// ----------------------------------------------------------------------------
// smc_checker
// Port-level checks of the small matrix calculator.
// ----------------------------------------------------------------------------
module smc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic [1:0]  i_op,
    input logic        o_valid,
    input logic [2:0]  o_out_row,
    input logic [2:0]  o_out_col,
    input logic [31:0] o_out_value,
    input logic [1:0]  o_status,
    input logic        o_order,
    input logic        o_last
);

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != smc_pkg::ST_OK) |->
            (o_last && o_out_value == 32'd0 && o_out_row == 3'd0 &&
             o_out_col == 3'd0 && !o_order))
        else $error("error transaction not a lone zero result");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_op == smc_pkg::OP_START) |=> o_busy)
        else $error("start transaction did not raise busy");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_op == smc_pkg::OP_WR_A || i_op == smc_pkg::OP_WR_B))
            |=> !o_valid)
        else $error("write transaction produced a result");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result straight after last");

endmodule

bind small_matrix_calculator smc_checker u_smc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .i_op        (i_op),
    .o_valid     (o_valid),
    .o_out_row   (o_out_row),
    .o_out_col   (o_out_col),
    .o_out_value (o_out_value),
    .o_status    (o_status),
    .o_order     (o_order),
    .o_last      (o_last)
);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the small matrix calculator: loads A and B, runs
// add, subtract, scale and product over many shapes and register settings,
// and compares every result element against a predicted matrix.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        logic [1:0]  status;
        logic        order;
        logic        last;
    } t_elem;

    class matrix_scoreboard;
        logic [15:0] mat_a [64];
        logic [15:0] mat_b [64];
        logic [15:0] regs [6];
        t_elem       pending [$];
        int          errors;

        function new();
            regs[0] = 0; regs[1] = 1; regs[2] = 1; regs[3] = 1; regs[4] = 1; regs[5] = 0;
            errors = 0;
        endfunction

        function void set_reg(int idx, logic [15:0] d);
            regs[idx] = d;
        endfunction

        function void push(int r, int c, longint v, int st, int ord, bit lst);
            t_elem e;
            e.row = r; e.col = c; e.status = st; e.order = ord; e.last = lst;
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            e.value = v[31:0];
            pending.push_back(e);
        endfunction

        function bit size_good(logic [15:0] d);
            return d >= 1 && d <= smc_pkg::MAX_DIM && d <= smc_pkg::SIDE;
        endfunction

        function longint el(bit from_b, int r, int c);
            logic signed [15:0] x;
            x = from_b ? mat_b[r*8+c] : mat_a[r*8+c];
            return longint'(x);
        endfunction

        function void note_input(smc_pkg::t_op op, int r, int c, logic [15:0] v);
            int     ra, ca, rb, cb, nr, nc, inner, ord;
            longint s, a;
            logic signed [15:0] k;
            ra = regs[1][3:0]; ca = regs[2][3:0]; rb = regs[3][3:0]; cb = regs[4][3:0];
            k = regs[5];
            if (op == smc_pkg::OP_WR_A) mat_a[r*8+c] = v;
            else if (op == smc_pkg::OP_WR_B) mat_b[r*8+c] = v;
            else if (op == smc_pkg::OP_START) begin
                if (smc_pkg::t_mode'(regs[0][1:0]) != smc_pkg::M_MAC) begin
                    if (!size_good(ra)) begin
                        push(0, 0, 0, smc_pkg::ST_RANGE, 0, 1);
                        return;
                    end
                    for (int i = 0; i < ra; i++)
                        for (int j = 0; j < ra; j++) begin
                            a = el(0, i, j);
                            case (smc_pkg::t_mode'(regs[0][1:0]))
                                smc_pkg::M_ADD: s = a + el(1, i, j);
                                smc_pkg::M_SUB: s = a - el(1, i, j);
                                default: s = a * longint'(k);
                            endcase
                            push(i, j, s, smc_pkg::ST_OK, 0, i == ra-1 && j == ra-1);
                        end
                    return;
                end
                if (!size_good(ra) || !size_good(ca) || !size_good(rb) || !size_good(cb)) begin
                    push(0, 0, 0, smc_pkg::ST_RANGE, 0, 1);
                    return;
                end
                if (ca == rb) begin
                    ord = 0; nr = ra; nc = cb; inner = ca;
                end else if (cb == ra) begin
                    ord = 1; nr = rb; nc = ca; inner = ra;
                end else begin
                    push(0, 0, 0, smc_pkg::ST_SHAPE, 0, 1);
                    return;
                end
                for (int i = 0; i < nr; i++)
                    for (int j = 0; j < nc; j++) begin
                        s = 0;
                        for (int q = 0; q < inner; q++)
                            s += ord ? el(1, i, q) * el(0, q, j) : el(0, i, q) * el(1, q, j);
                        s = s + 128;
                        s = s >>> 8;
                        push(i, j, s, smc_pkg::ST_OK, ord, i == nr-1 && j == nc-1);
                    end
            end
        endfunction

        function void check(logic [2:0] r, logic [2:0] c, logic [31:0] v, logic [1:0] st,
                            logic ord, logic lst);
            t_elem e;
            if (pending.size() == 0) begin
                $error("unexpected result row %0d col %0d", r, c);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (r !== e.row) begin $error("out_row exp %0d got %0d", e.row, r); errors++; end
            if (c !== e.col) begin $error("out_col exp %0d got %0d", e.col, c); errors++; end
            if (v !== e.value) begin
                $error("out_value exp %0h got %0h", e.value, v); errors++;
            end
            if (st !== e.status) begin
                $error("status exp %0d got %0d", e.status, st); errors++;
            end
            if (ord !== e.order) begin $error("order exp %0d got %0d", e.order, ord); errors++; end
            if (lst !== e.last) begin $error("last exp %0d got %0d", e.last, lst); errors++; end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_start = 0;
    logic               o_busy;
    logic [1:0]         i_op = 0;
    logic [2:0]         i_row = 0;
    logic [2:0]         i_col = 0;
    logic signed [15:0] i_value = 0;
    logic               i_cfg_we = 0;
    logic [2:0]         i_cfg_index = 0;
    logic [15:0]        i_cfg_data = 0;
    logic               o_valid;
    logic [2:0]         o_out_row;
    logic [2:0]         o_out_col;
    logic signed [31:0] o_out_value;
    logic [1:0]         o_status;
    logic               o_order;
    logic               o_last;

    matrix_scoreboard sb = new();
    int  burst_left = 0;
    longint cycle_count = 0;

    small_matrix_calculator dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check(o_out_row, o_out_col, o_out_value, o_status, o_order, o_last);
    end

    task automatic send(smc_pkg::t_op op, int r, int c, logic [15:0] v);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                i_start <= 0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_start <= 1;
        i_op <= op; i_row <= r; i_col <= c; i_value <= v;
        do @(posedge i_clk); while (o_busy);
        sb.note_input(op, r, c, v);
    endtask

    task automatic drain();
        i_start <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] d);
        i_cfg_we <= 1; i_cfg_index <= idx; i_cfg_data <= d;
        @(posedge i_clk);
        sb.set_reg(idx, d);
    endtask

    task automatic fill_all(bit extremes);
        logic [15:0] v;
        for (int r = 0; r < 8; r++)
            for (int c = 0; c < 8; c++) begin
                v = extremes ? (((r + c) % 2) ? 16'h8000 : 16'h7FFF) : 16'($urandom);
                send(smc_pkg::OP_WR_A, r, c, v);
                v = extremes ? ((r % 2) ? 16'h8000 : 16'h7FFF) : 16'($urandom);
                send(smc_pkg::OP_WR_B, r, c, v);
            end
    endtask

    task automatic run(int mode, int ra, int ca, int rb, int cb, logic [15:0] k);
        drain();
        write_reg(smc_pkg::CFG_OPERATION, mode);
        write_reg(smc_pkg::CFG_ROWS_A, ra);
        write_reg(smc_pkg::CFG_COLS_A, ca);
        write_reg(smc_pkg::CFG_ROWS_B, rb);
        write_reg(smc_pkg::CFG_COLS_B, cb);
        write_reg(smc_pkg::CFG_SCALAR, k);
        i_cfg_we <= 0;
    endtask

    function automatic int pick_dim();
        int x;
        x = $urandom_range(0, 19);
        if (x == 0) return 0;
        if (x == 1) return $urandom_range(9, 15);
        if (x < 4) return 8;
        return $urandom_range(1, 4);
    endfunction

    initial begin
        int ra, ca, rb, cb, m, n;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        fill_all(1);
        send(smc_pkg::OP_NONE, 7, 7, 16'hFFFF);
        for (int md = 0; md < 3; md++) begin
            run(md, 8, 1, 1, 1, 16'h8000);
            send(smc_pkg::OP_START, 0, 0, 0);
        end
        run(smc_pkg::M_SCL, 8, 1, 1, 1, 16'h7FFF);
        send(smc_pkg::OP_START, 7, 7, 0);
        run(smc_pkg::M_MAC, 8, 8, 8, 8, 0);
        send(smc_pkg::OP_START, 0, 0, 0);
        run(smc_pkg::M_MAC, 2, 3, 4, 2, 0);
        send(smc_pkg::OP_START, 0, 0, 0);
        run(smc_pkg::M_MAC, 2, 3, 4, 5, 0);
        send(smc_pkg::OP_START, 0, 0, 0);
        run(smc_pkg::M_ADD, 0, 1, 1, 1, 0);
        send(smc_pkg::OP_START, 0, 0, 0);
        run(smc_pkg::M_MAC, 3, 9, 3, 3, 0);
        send(smc_pkg::OP_START, 0, 0, 0);
        run(smc_pkg::M_MAC, 15, 15, 15, 15, 16'hFFFF);
        send(smc_pkg::OP_START, 0, 0, 0);

        fill_all(0);
        for (int t = 0; t < 30; t++) begin
            ra = pick_dim(); ca = pick_dim(); rb = pick_dim(); cb = pick_dim();
            m = $urandom_range(0, 3);
            if (m == smc_pkg::M_MAC && $urandom_range(0, 3) != 0) rb = ca;
            run(m, ra, ca, rb, cb, 16'($urandom));
            n = $urandom_range(0, 4);
            for (int w = 0; w < n; w++)
                send(smc_pkg::t_op'($urandom_range(0, 1)), $urandom_range(0, 7),
                     $urandom_range(0, 7), 16'($urandom));
            if ($urandom_range(0, 9) == 0)
                send(smc_pkg::OP_NONE, $urandom_range(0, 7), 0, 16'($urandom));
            send(smc_pkg::OP_START, $urandom_range(0, 7), $urandom_range(0, 7),
                 16'($urandom));
        end
        drain();
        if (sb.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule

// ===== small_matrix_calculator.f =====
sv/smc_pkg.sv
sv/smc_cell.sv
sv/smc_ctrl.sv
sv/small_matrix_calculator.sv
sv/smc_checker.sv
tb/sv/tb.sv
